### hdl/pe_pkg.sv
// ----------------------------------------------------------------------------
// pe_pkg: shared types and constants for path edge ordering
// Field widths, word structs, status codes and node table operations.
// ----------------------------------------------------------------------------
package pe_pkg;

	localparam int ROADS_DEF = 64;
	localparam int NODES_DEF = 128;

	localparam int ROAD_W = 6;
	localparam int NODE_W = 7;
	localparam int STAT_W = 2;

	localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
	localparam logic [STAT_W-1:0] ST_NO_START    = 2'd1;
	localparam logic [STAT_W-1:0] ST_MULTI_START = 2'd2;
	localparam logic [STAT_W-1:0] ST_OVERFLOW    = 2'd3;

	typedef struct packed {
		logic [ROAD_W-1:0] road_id;
		logic [NODE_W-1:0] start_node;
		logic [NODE_W-1:0] end_node;
		logic              last;
	} item_t;

	typedef struct packed {
		logic [ROAD_W-1:0] out_road;
		logic [NODE_W-1:0] out_start;
		logic [NODE_W-1:0] out_end;
		logic [STAT_W-1:0] status;
		logic              out_last;
	} result_t;

	typedef enum logic [2:0] {
		NODE_NOP,
		NODE_READ,
		NODE_SET_OUT,
		NODE_SET_IN,
		NODE_CLEAR
	} node_op_t;

endpackage

### hdl/pe_node_store.sv
// ----------------------------------------------------------------------------
// pe_node_store: per-node table
// Holds seen bit, first outgoing road and first incoming road for every node.
// Registered read; set operations merge into the entry read the cycle before.
// ----------------------------------------------------------------------------
module pe_node_store
	import pe_pkg::*;
#(
	parameter int ROADS = ROADS_DEF,
	parameter int NODES = NODES_DEF
) (
	input  logic                     clk,
	input  node_op_t                 op,
	input  logic [$clog2(NODES)-1:0] addr,
	input  logic [$clog2(ROADS)-1:0] road,
	output logic                     rd_seen,
	output logic [$clog2(ROADS)-1:0] rd_out_road,
	output logic [$clog2(ROADS)-1:0] rd_in_road
);

	localparam int RW = $clog2(ROADS);

	typedef struct packed {
		logic          seen;
		logic [RW-1:0] out_road;
		logic [RW-1:0] in_road;
	} node_ent_t;

	node_ent_t mem [NODES];
	node_ent_t rdata_q;
	node_ent_t wdata;
	logic      we;

	always_comb begin
		we    = 1'b0;
		wdata = rdata_q;
		case (op)
			NODE_SET_OUT: begin
				we            = 1'b1;
				wdata.seen    = 1'b1;
				wdata.out_road = (rdata_q.out_road == '0) ? road : rdata_q.out_road;
			end
			NODE_SET_IN: begin
				we            = 1'b1;
				wdata.seen    = 1'b1;
				wdata.in_road = (rdata_q.in_road == '0) ? road : rdata_q.in_road;
			end
			NODE_CLEAR: begin
				we    = 1'b1;
				wdata = '0;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (op == NODE_READ) begin
			rdata_q <= mem[addr];
		end
	end

	assign rd_seen     = rdata_q.seen;
	assign rd_out_road = rdata_q.out_road;
	assign rd_in_road  = rdata_q.in_road;

endmodule

### hdl/path_edge_ordering.sv
// ----------------------------------------------------------------------------
// path_edge_ordering: orders a set of road segments into one path
// A valid segment word is accepted and then loaded by two read-modify-writes
// on the node table; a word that loads nothing and is not last is only accepted.
// A last word adds a node scan; if it finds exactly one start node, the walk
// follows (a node table read of the start node, then per emitted road a road
// table read and a node table read), else a status result; then a clear sweep
// of all NODES entries. Reset runs the sweep; item_stall is high until done.
module path_edge_ordering
	import pe_pkg::*;
#(
	parameter int ROADS = ROADS_DEF,
	parameter int NODES = NODES_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int RW = $clog2(ROADS);
	localparam int NW = $clog2(NODES);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_LD_S_RD,
		S_LD_S_WR,
		S_LD_E_RD,
		S_LD_E_WR,
		S_SCAN,
		S_SCAN_END,
		S_DECIDE,
		S_W_NODE,
		S_W_ROAD,
		S_W_RR,
		S_W_NEXT,
		S_W_EMIT
	} state_t;

	state_t        state_q;
	logic [NW-1:0] ci_q;
	logic [NW-1:0] si_q;
	logic          scan_vld_s1;
	logic [NW-1:0] scan_idx_s1;
	logic [1:0]    cnt_q;
	logic [RW-1:0] road_q;
	logic [NW-1:0] sn_q;
	logic [NW-1:0] en_q;
	logic          last_q;
	logic [NW-1:0] cur_q;
	logic [NW-1:0] e_q;
	logic [RW-1:0] r_q;
	logic [RW-1:0] n_q;
	logic          result_valid_q;
	result_t       result_q;

	logic [NW-1:0] road_end [ROADS];
	logic [NW-1:0] road_rdata_q;

	node_op_t      node_op;
	logic [NW-1:0] node_addr;
	logic          rd_seen;
	logic [RW-1:0] rd_out_road;
	logic [RW-1:0] rd_in_road;

	logic          accept;
	logic          ld_ok;
	logic          out_free;
	logic          ovf;

	pe_node_store #(
		.ROADS(ROADS),
		.NODES(NODES)
	) u_node (
		.clk        (clk),
		.op         (node_op),
		.addr       (node_addr),
		.road       (road_q),
		.rd_seen    (rd_seen),
		.rd_out_road(rd_out_road),
		.rd_in_road (rd_in_road)
	);

	assign item_stall   = (state_q != S_IDLE);
	assign accept       = item_valid && !item_stall;
	assign ld_ok        = (item.road_id != '0) && (32'(item.road_id) < ROADS) &&
	                      (32'(item.start_node) < NODES) && (32'(item.end_node) < NODES);
	assign out_free     = !result_valid_q || !result_stall;
	assign ovf          = (n_q == RW'(ROADS - 1)) && (rd_out_road != '0);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		node_op   = NODE_NOP;
		node_addr = cur_q;
		case (state_q)
			S_CLEAR: begin
				node_op   = NODE_CLEAR;
				node_addr = ci_q;
			end
			S_LD_S_RD: begin
				node_op   = NODE_READ;
				node_addr = sn_q;
			end
			S_LD_S_WR: begin
				node_op   = NODE_SET_OUT;
				node_addr = sn_q;
			end
			S_LD_E_RD: begin
				node_op   = NODE_READ;
				node_addr = en_q;
			end
			S_LD_E_WR: begin
				node_op   = NODE_SET_IN;
				node_addr = en_q;
			end
			S_SCAN: begin
				node_op   = NODE_READ;
				node_addr = si_q;
			end
			S_W_NODE: begin
				node_op   = NODE_READ;
				node_addr = cur_q;
			end
			S_W_NEXT: begin
				node_op   = NODE_READ;
				node_addr = road_rdata_q;
			end
			default: begin
				node_op = NODE_NOP;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_LD_S_WR) begin
			road_end[road_q] <= en_q;
		end
		if (state_q == S_W_RR) begin
			road_rdata_q <= road_end[r_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			ci_q           <= '0;
			si_q           <= '0;
			scan_vld_s1    <= 1'b0;
			scan_idx_s1    <= '0;
			cnt_q          <= '0;
			road_q         <= '0;
			sn_q           <= '0;
			en_q           <= '0;
			last_q         <= 1'b0;
			cur_q          <= '0;
			e_q            <= '0;
			r_q            <= '0;
			n_q            <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end

			scan_vld_s1 <= (state_q == S_SCAN);
			scan_idx_s1 <= si_q;
			if (scan_vld_s1 && rd_seen && (rd_in_road == '0)) begin
				cur_q <= scan_idx_s1;
				if (cnt_q != 2'd2) begin
					cnt_q <= cnt_q + 2'd1;
				end
			end

			case (state_q)
				S_CLEAR: begin
					ci_q <= ci_q + NW'(1);
					if (ci_q == NW'(NODES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						road_q <= RW'(item.road_id);
						sn_q   <= NW'(item.start_node);
						en_q   <= NW'(item.end_node);
						last_q <= item.last;
						if (ld_ok) begin
							state_q <= S_LD_S_RD;
						end else if (item.last) begin
							si_q    <= NW'(1);
							cnt_q   <= '0;
							state_q <= S_SCAN;
						end
					end
				end
				S_LD_S_RD: state_q <= S_LD_S_WR;
				S_LD_S_WR: state_q <= S_LD_E_RD;
				S_LD_E_RD: state_q <= S_LD_E_WR;
				S_LD_E_WR: begin
					if (last_q) begin
						si_q    <= NW'(1);
						cnt_q   <= '0;
						state_q <= S_SCAN;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					si_q <= si_q + NW'(1);
					if (si_q == NW'(NODES - 1)) begin
						state_q <= S_SCAN_END;
					end
				end
				S_SCAN_END: state_q <= S_DECIDE;
				S_DECIDE: begin
					if (cnt_q == 2'd1) begin
						state_q <= S_W_NODE;
					end else if (out_free) begin
						result_valid_q     <= 1'b1;
						result_q.out_road  <= '0;
						result_q.out_start <= '0;
						result_q.out_end   <= '0;
						result_q.status    <= (cnt_q == 2'd0) ? ST_NO_START : ST_MULTI_START;
						result_q.out_last  <= 1'b1;
						ci_q               <= '0;
						state_q            <= S_CLEAR;
					end
				end
				S_W_NODE: state_q <= S_W_ROAD;
				S_W_ROAD: begin
					r_q <= rd_out_road;
					n_q <= '0;
					if (rd_out_road == '0) begin
						ci_q    <= '0;
						state_q <= S_CLEAR;
					end else begin
						state_q <= S_W_RR;
					end
				end
				S_W_RR: state_q <= S_W_NEXT;
				S_W_NEXT: begin
					e_q     <= road_rdata_q;
					state_q <= S_W_EMIT;
				end
				S_W_EMIT: begin
					if (out_free) begin
						result_valid_q     <= 1'b1;
						result_q.out_road  <= ROAD_W'(r_q);
						result_q.out_start <= NODE_W'(cur_q);
						result_q.out_end   <= NODE_W'(e_q);
						result_q.status    <= ovf ? ST_OVERFLOW : ST_OK;
						result_q.out_last  <= ovf || (rd_out_road == '0);
						if (ovf || (rd_out_road == '0)) begin
							ci_q    <= '0;
							state_q <= S_CLEAR;
						end else begin
							r_q     <= rd_out_road;
							cur_q   <= e_q;
							n_q     <= n_q + RW'(1);
							state_q <= S_W_RR;
						end
					end
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

endmodule
